// ===== design/columnwise_delta_double_delta_codec_core_macros.svh =====
// Assertion macros used by the codec core module.
`ifndef COLUMNWISE_DELTA_DOUBLE_DELTA_CODEC_CORE_MACROS_SVH
`define COLUMNWISE_DELTA_DOUBLE_DELTA_CODEC_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock and idle during reset.
`define CDDC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and idle during reset.
`define CDDC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/cddc_pkg.sv =====
// Shared types and constants of the column-wise delta codec.
package cddc_pkg;

   localparam int MAX_COLUMNS = 256;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int NCOL_W      = 9;
   localparam int ELEM_W      = 16;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_COLUMNS   = 4'd0,
      CSR_WIDE_ELEMENTS = 4'd1,
      CSR_DOUBLE_MODE   = 4'd2,
      CSR_DECODE_DIR    = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic [NCOL_W-1:0] num_columns;
      logic              wide_elements;
      logic              double_mode;
      logic              decode_dir;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             first_row;
   } pos_type;

endpackage

// ===== design/cddc_req_if.sv =====
// Input sample channel: valid/ready with sample and end-of-stream flag.
interface cddc_req_if import cddc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ELEM_W-1:0] sample_in;
   logic              end_of_stream;

   modport source (output valid, output sample_in, output end_of_stream, input ready);
   modport sink (input valid, input sample_in, input end_of_stream, output ready);
endinterface

// ===== design/cddc_rsp_if.sv =====
// Result channel: valid/ready with coded sample and last flag.
interface cddc_rsp_if import cddc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ELEM_W-1:0] sample_out;
   logic              last_out;

   modport source (output valid, output sample_out, output last_out, input ready);
   modport sink (input valid, input sample_out, input last_out, output ready);
endinterface

// ===== design/cddc_csr_if.sv =====
// Configuration write channel: valid/ready with register index and data.
interface cddc_csr_if import cddc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/cddc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
module cddc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/cddc_csr.sv =====
// Configuration register file of the codec.
module cddc_csr import cddc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   cddc_csr_if.sink     csr_if,
   output cfg_type      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_NUM_COLUMNS:   cfg_in.num_columns   = csr_if.data[NCOL_W-1:0];
            CSR_WIDE_ELEMENTS: cfg_in.wide_elements = csr_if.data[0];
            CSR_DOUBLE_MODE:   cfg_in.double_mode   = csr_if.data[0];
            CSR_DECODE_DIR:    cfg_in.decode_dir    = csr_if.data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_columns   <= NCOL_W'(1);
         cfg_ff.wide_elements <= 1'b0;
         cfg_ff.double_mode   <= 1'b0;
         cfg_ff.decode_dir    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/cddc_position.sv =====
// Stream position tracker: current column and first-row flag.
module cddc_position import cddc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    end_of_stream,
   input  cfg_type cfg,
   output pos_type pos
);

   logic [COL_W-1:0]  col_ff, col_in;
   logic              first_row_ff, first_row_in;
   logic [NCOL_W-1:0] ncols;
   logic [NCOL_W-1:0] col_next;

   always_comb begin
      // zero counts as one column, anything above the store saturates
      if (cfg.num_columns == '0) begin
         ncols = NCOL_W'(1);
      end else if (cfg.num_columns > NCOL_W'(MAX_COLUMNS)) begin
         ncols = NCOL_W'(MAX_COLUMNS);
      end else begin
         ncols = cfg.num_columns;
      end
      col_next = {{(NCOL_W-COL_W){1'b0}}, col_ff} + NCOL_W'(1);

      col_in       = col_ff;
      first_row_in = first_row_ff;
      if (advance) begin
         if (end_of_stream) begin
            col_in       = '0;
            first_row_in = 1'b1;
         end else if (col_next >= ncols) begin
            col_in       = '0;
            first_row_in = 1'b0;
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
      end else begin
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
      end
   end

   assign pos.col       = col_ff;
   assign pos.first_row = first_row_ff;

endmodule

// ===== design/columnwise_delta_double_delta_codec_core.sv =====
// Pipeline: a sample is registered in stage s1, then its result in the output register;
// a result channel that is not ready stalls both. Throughput: one sample per cycle while
// the result channel is ready, set by the per-column read-modify-write of the
// previous-value and previous-delta memories (one read port, one write port each).
// Back-to-back samples of the same column are forwarded around the memory.
// Reset: column 0, first row, control registers to reset values; memories are not cleared.
module columnwise_delta_double_delta_codec_core import cddc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   cddc_req_if.sink     req_if,
   cddc_rsp_if.source   rsp_if,
   cddc_csr_if.sink     csr_if
);

`include "columnwise_delta_double_delta_codec_core_macros.svh"

   cfg_type cfg;
   pos_type pos;

   logic req_xfer;
   logic s1_adv;

   logic              s1_valid_ff, s1_valid_in;
   logic [ELEM_W-1:0] s1_sample_ff;
   logic              s1_eos_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              s1_first_ff;
   logic              fwd_ff, fwd_in;
   logic [ELEM_W-1:0] fwd_value_ff;
   logic [ELEM_W-1:0] fwd_delta_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0] rsp_sample_ff;
   logic              rsp_last_ff;

   logic [ELEM_W-1:0] rd_value, rd_delta;
   logic [ELEM_W-1:0] mask, x, pv, pd;
   logic [ELEM_W-1:0] new_value, new_delta, result;

   cddc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   cddc_position u_position (
      .clock         (clock),
      .reset         (reset),
      .advance       (req_xfer),
      .end_of_stream (req_if.end_of_stream),
      .cfg           (cfg),
      .pos           (pos)
   );

   cddc_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_COLUMNS)) u_value_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (new_value),
      .rd_en   (req_xfer),
      .rd_addr (pos.col),
      .rd_data (rd_value)
   );

   cddc_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_COLUMNS)) u_delta_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (new_delta),
      .rd_en   (req_xfer),
      .rd_addr (pos.col),
      .rd_data (rd_delta)
   );

   assign s1_adv        = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !s1_valid_ff || s1_adv;
   assign req_xfer      = req_if.valid && req_if.ready;

   always_comb begin
      // the memory returns stale data when the item ahead writes the same column
      fwd_in      = s1_adv && (s1_col_ff == pos.col);
      s1_valid_in = req_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      mask = cfg.wide_elements ? {ELEM_W{1'b1}} : {{(ELEM_W/2){1'b0}}, {(ELEM_W/2){1'b1}}};
      x    = s1_sample_ff & mask;
      if (s1_first_ff) begin
         pv = '0;
         pd = '0;
      end else if (fwd_ff) begin
         pv = fwd_value_ff;
         pd = fwd_delta_ff;
      end else begin
         pv = rd_value;
         pd = rd_delta;
      end

      if (!cfg.decode_dir) begin
         new_value = x;
         new_delta = (x - pv) & mask;
         result    = cfg.double_mode ? ((new_delta - pd) & mask) : new_delta;
      end else begin
         new_delta = cfg.double_mode ? ((x + pd) & mask) : x;
         new_value = (pv + new_delta) & mask;
         result    = new_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_sample_ff <= req_if.sample_in;
         s1_eos_ff    <= req_if.end_of_stream;
         s1_col_ff    <= pos.col;
         s1_first_ff  <= pos.first_row;
         fwd_value_ff <= new_value;
         fwd_delta_ff <= new_delta;
      end
      if (s1_adv) begin
         rsp_sample_ff <= result;
         rsp_last_ff   <= s1_eos_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sample_out = rsp_sample_ff;
   assign rsp_if.last_out   = rsp_last_ff;

   `CDDC_ASSERT_NEXT(a_xfer_fills_stage, req_xfer, s1_valid_ff, "accepted sample missing in stage")
   `CDDC_ASSERT_NEXT(a_stall_holds_col, s1_valid_ff && !s1_adv, $stable(s1_col_ff) && s1_valid_ff, "stalled stage lost its column")
   `CDDC_ASSERT_NEXT(a_adv_fills_rsp, s1_adv, rsp_valid_ff, "stage advanced without a result")
   `CDDC_ASSERT_NOW(a_fwd_same_col, req_xfer && fwd_in, s1_valid_ff && (s1_col_ff == pos.col), "forwarding from a different column")

endmodule
